// File: src/cdwq_pkg.sv
// Package: shared types and constants for the coalescing deferred work queue.
package cdwq_pkg;

   localparam logic [1:0] REQ_REGISTER   = 2'd0;
   localparam logic [1:0] REQ_UNREGISTER = 2'd1;
   localparam logic [1:0] REQ_RAISE      = 2'd2;
   localparam logic [1:0] REQ_RUN        = 2'd3;

   localparam int HANDLE_W = 31;
   localparam int CB_W     = 32;
   localparam int BUDGET_W = 8;
   localparam int COUNT_W  = 6;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [HANDLE_W-1:0] handle;
      logic [CB_W-1:0]     callback_id;
      logic [CB_W-1:0]     callback_arg;
      logic [BUDGET_W-1:0] budget;
   } req_type_type;

   typedef struct packed {
      logic                status;
      logic [HANDLE_W-1:0] result_handle;
      logic                dispatch_valid;
      logic [CB_W-1:0]     dispatch_id;
      logic [CB_W-1:0]     dispatch_arg;
      logic [COUNT_W-1:0]  ran_count;
      logic                last;
   } rsp_type;

endpackage

// File: src/coalescing_deferred_work_queue_unit.sv
// Top level: coalescing deferred work queue, slot table in memory with a sequencer.
//
//  channel | ports             | direction | payload
//  --------+-------------------+-----------+----------------
//  request | req_valid/ready   | in        | req_type_type
//  result  | rsp_valid/ready   | out       | rsp_type
//
// Register searches for the lowest free slot over the used bits, one slot a cycle,
// then writes it. Unregister and raise scan the handle memory one slot a cycle;
// unregister of a queued slot then walks the link memory, one hop per ST_WALK and
// ST_WCHK pass. Run emits each dispatch through ST_RUN, ST_RUND and ST_OUT, and
// the final count result through ST_RUN and ST_OUT.
// Reset clears valid bits and the FIFO head/tail at once; no clearing pass.
// A stalled result holds the sequencer; one transaction is worked at a time.
module coalescing_deferred_work_queue_unit
   import cdwq_pkg::*;
#(
   parameter int NUM_SLOTS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_payload
);
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_FREE   = 4'd1;  // search lowest free slot
   localparam logic [3:0] ST_FIND   = 4'd2;  // issue handle read
   localparam logic [3:0] ST_CMP    = 4'd3;  // compare handle read data
   localparam logic [3:0] ST_WALK   = 4'd4;  // issue link read for unlink
   localparam logic [3:0] ST_WCHK   = 4'd5;  // link data back
   localparam logic [3:0] ST_RUN    = 4'd6;  // issue reads for head
   localparam logic [3:0] ST_RUND   = 4'd7;  // data back, emit dispatch
   localparam logic [3:0] ST_OUT    = 4'd8;  // hold result until taken
   localparam logic [3:0] ST_FIXTL  = 4'd9;  // unused; the prev link is written in ST_WCHK

   logic [3:0]          state_ff, state_in;
   logic [NUM_SLOTS-1:0] used_ff, used_in, queued_ff, queued_in;
   logic [IDX_W-1:0]    first_ff, first_in, final_ff, final_in;
   logic                empty_ff, empty_in;
   logic [31:0]         counter_ff, counter_in;
   req_type_type        req_ff, req_in;
   logic [IDX_W-1:0]    idx_ff, idx_in, prev_ff, prev_in, tgt_ff, tgt_in;
   logic                have_prev_ff, have_prev_in;
   logic [CNT_W-1:0]    ran_ff, ran_in, steps_ff, steps_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          after_ff, after_in;   // state after result is taken

   logic                sm_wr;
   logic [IDX_W-1:0]    sm_ridx;
   logic [HANDLE_W-1:0] sm_rhandle;
   logic [CB_W-1:0]     sm_rid, sm_rarg;
   logic                lm_wr;
   logic [IDX_W-1:0]    lm_widx, lm_wdata, lm_ridx, lm_rdata;

   cdwq_slot_mem #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W)) u_slot (
      .clock(clock), .wr_en(sm_wr), .wr_idx(idx_ff),
      .wr_handle(counter_ff[HANDLE_W-1:0]), .wr_id(req_ff.callback_id),
      .wr_arg(req_ff.callback_arg), .rd_idx(sm_ridx),
      .rd_handle(sm_rhandle), .rd_id(sm_rid), .rd_arg(sm_rarg)
   );

   cdwq_link_mem #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W)) u_link (
      .clock(clock), .wr_en(lm_wr), .wr_idx(lm_widx), .wr_data(lm_wdata),
      .rd_idx(lm_ridx), .rd_data(lm_rdata)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   function automatic rsp_type simple_rsp(input logic fail, input logic [HANDLE_W-1:0] h);
      rsp_type r;
      r = '0;
      r.status        = fail;
      r.result_handle = h;
      r.last          = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      queued_in    = queued_ff;
      first_in     = first_ff;
      final_in     = final_ff;
      empty_in     = empty_ff;
      counter_in   = counter_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      tgt_in       = tgt_ff;
      have_prev_in = have_prev_ff;
      ran_in       = ran_ff;
      steps_in     = steps_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      after_in     = after_ff;
      sm_wr        = 1'b0;
      sm_ridx      = idx_ff;
      lm_wr        = 1'b0;
      lm_widx      = prev_ff;
      lm_wdata     = lm_rdata;
      lm_ridx      = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               idx_in   = '0;
               ran_in   = '0;
               steps_in = '0;
               unique case (req_payload.req_type)
                  REQ_REGISTER: begin
                     if (req_payload.callback_id == '0) begin
                        rsp_in = simple_rsp(1'b1, '0);
                        state_in = ST_OUT;
                        after_in = ST_IDLE;
                     end else state_in = ST_FREE;
                  end
                  REQ_UNREGISTER, REQ_RAISE: begin
                     if (req_payload.handle == '0) begin
                        rsp_in = simple_rsp(1'b1, '0);
                        state_in = ST_OUT;
                        after_in = ST_IDLE;
                     end else state_in = ST_FIND;
                  end
                  default: state_in = ST_RUN;
               endcase
            end
         end
         ST_FREE: begin
            if (!used_ff[idx_ff]) begin
               state_in = ST_OUT;
               after_in = ST_IDLE;
               if (counter_ff == '0 || counter_ff > 32'h7FFF_FFFF) begin
                  rsp_in = simple_rsp(1'b1, '0);
               end else begin
                  sm_wr             = 1'b1;
                  used_in[idx_ff]   = 1'b1;
                  queued_in[idx_ff] = 1'b0;
                  rsp_in            = simple_rsp(1'b0, counter_ff[HANDLE_W-1:0]);
                  counter_in        = counter_ff + 32'd1;
               end
            end else if (idx_ff == IDX_W'(NUM_SLOTS - 1)) begin
               rsp_in = simple_rsp(1'b1, '0);
               state_in = ST_OUT;
               after_in = ST_IDLE;
            end else idx_in = idx_ff + 1'b1;
         end
         ST_FIND: state_in = ST_CMP;   // read of idx_ff issued
         ST_CMP: begin
            if (used_ff[idx_ff] && sm_rhandle == req_ff.handle) begin
               state_in = ST_OUT;
               after_in = ST_IDLE;
               rsp_in   = simple_rsp(1'b0, '0);
               if (req_ff.req_type == REQ_UNREGISTER) begin
                  used_in[idx_ff]   = 1'b0;
                  queued_in[idx_ff] = 1'b0;
                  if (queued_ff[idx_ff] && !empty_ff) begin
                     tgt_in       = idx_ff;
                     idx_in       = first_ff;
                     have_prev_in = 1'b0;
                     steps_in     = '0;
                     state_in     = ST_WALK;
                  end
               end else if (!queued_ff[idx_ff]) begin
                  queued_in[idx_ff] = 1'b1;
                  if (empty_ff) begin
                     first_in = idx_ff;
                     empty_in = 1'b0;
                  end else begin
                     lm_wr    = 1'b1;
                     lm_widx  = final_ff;
                     lm_wdata = idx_ff;
                  end
                  final_in = idx_ff;
               end
            end else if (idx_ff == IDX_W'(NUM_SLOTS - 1)) begin
               rsp_in = simple_rsp(1'b1, '0);
               state_in = ST_OUT;
               after_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               sm_ridx  = idx_ff + 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_WALK: begin
            state_in = ST_WCHK;   // link read of idx_ff issued
         end
         ST_WCHK: begin
            // lm_rdata holds link[idx_ff]
            if (idx_ff == tgt_ff) begin
               if (!have_prev_ff) begin
                  if (idx_ff == final_ff) empty_in = 1'b1;
                  else first_in = lm_rdata;
                  state_in = ST_OUT;
               end else begin
                  lm_wr    = 1'b1;
                  lm_widx  = prev_ff;
                  lm_wdata = lm_rdata;
                  if (idx_ff == final_ff) final_in = prev_ff;
                  state_in = ST_OUT;
               end
            end else if (idx_ff == final_ff ||
                         steps_ff == CNT_W'(NUM_SLOTS - 1)) begin
               state_in = ST_OUT;
            end else begin
               prev_in      = idx_ff;
               have_prev_in = 1'b1;
               idx_in       = lm_rdata;
               steps_in     = steps_ff + 1'b1;
               state_in     = ST_WALK;
            end
         end
         ST_RUN: begin
            if (!empty_ff && (req_ff.budget == '0 ||
                  32'(ran_ff) < 32'(req_ff.budget))
                  && ran_ff != CNT_W'(NUM_SLOTS)) begin
               sm_ridx  = first_ff;
               lm_ridx  = first_ff;
               idx_in   = first_ff;
               state_in = ST_RUND;
            end else begin
               rsp_in           = '0;
               rsp_in.ran_count = COUNT_W'(ran_ff);
               rsp_in.last      = 1'b1;
               state_in         = ST_OUT;
               after_in         = ST_IDLE;
            end
         end
         ST_RUND: begin
            if (idx_ff == final_ff) empty_in = 1'b1;
            else first_in = lm_rdata;
            queued_in[idx_ff]     = 1'b0;
            rsp_in                = '0;
            rsp_in.result_handle  = sm_rhandle;
            rsp_in.dispatch_valid = 1'b1;
            rsp_in.dispatch_id    = sm_rid;
            rsp_in.dispatch_arg   = sm_rarg;
            ran_in                = ran_ff + 1'b1;
            state_in              = ST_OUT;
            after_in              = ST_RUN;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) rsp_valid_in = 1'b1;
            else if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = after_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         queued_ff    <= '0;
         first_ff     <= '0;
         final_ff     <= '0;
         empty_ff     <= 1'b1;
         counter_ff   <= 32'd1;
         rsp_valid_ff <= 1'b0;
         after_ff     <= ST_IDLE;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         queued_ff    <= queued_in;
         first_ff     <= first_in;
         final_ff     <= final_in;
         empty_ff     <= empty_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
         after_ff     <= after_in;
      end
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      prev_ff      <= prev_in;
      tgt_ff       <= tgt_in;
      have_prev_ff <= have_prev_in;
      ran_ff       <= ran_in;
      steps_ff     <= steps_in;
      rsp_ff       <= rsp_in;
   end

   // A queued slot is always a used slot.
   a_queued_used: assert property (@(posedge clock) disable iff (reset)
      (queued_ff & ~used_ff) == '0) else $error("queued slot not in use");
   // Results are shown only while the sequencer waits on the result channel.
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_OUT) else $error("result outside hold state");
   // An empty FIFO has no queued slot.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (empty_ff && state_ff == ST_IDLE) |-> queued_ff == '0)
      else $error("queued slot while FIFO empty");
endmodule

// File: src/cdwq_slot_mem.sv
// Slot payload memory: handle, callback id and argument per slot, registered read.
module cdwq_slot_mem
   import cdwq_pkg::*;
#(
   parameter int NUM_SLOTS = 32,
   parameter int IDX_W     = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  logic [HANDLE_W-1:0] wr_handle,
   input  logic [CB_W-1:0]     wr_id,
   input  logic [CB_W-1:0]     wr_arg,
   input  logic [IDX_W-1:0]    rd_idx,
   output logic [HANDLE_W-1:0] rd_handle,
   output logic [CB_W-1:0]     rd_id,
   output logic [CB_W-1:0]     rd_arg
);
   logic [HANDLE_W-1:0] handle_mem [NUM_SLOTS];
   logic [CB_W-1:0]     id_mem     [NUM_SLOTS];
   logic [CB_W-1:0]     arg_mem    [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         handle_mem[wr_idx] <= wr_handle;
         id_mem[wr_idx]     <= wr_id;
         arg_mem[wr_idx]    <= wr_arg;
      end
      rd_handle <= handle_mem[rd_idx];
      rd_id     <= id_mem[rd_idx];
      rd_arg    <= arg_mem[rd_idx];
   end
endmodule

// File: src/cdwq_link_mem.sv
// Pending FIFO link memory: next slot per queued slot, registered read.
module cdwq_link_mem #(
   parameter int NUM_SLOTS = 32,
   parameter int IDX_W     = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [IDX_W-1:0] wr_data,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [IDX_W-1:0] rd_data
);
   logic [IDX_W-1:0] link_mem [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) link_mem[wr_idx] <= wr_data;
      rd_data <= link_mem[rd_idx];
   end
endmodule
